### src/tphq_pkg.sv
// package for the touch press/hold qualifier
// holds widths, register indexes, codes and the structs shared between modules
// no dependencies

package tphq_pkg;

    // field widths
    localparam int COORD_BITS    = 12;
    localparam int TIME_BITS     = 48;
    localparam int POINT_BITS    = 3;
    localparam int SIZE_BITS     = 13;
    localparam int HOLD_BITS     = 20;
    localparam int FAULT_BITS    = 2;

    // hold limit in microseconds: ms times 1000, and 1000 fits in 10 bits
    localparam int US_PER_MS     = 1000;
    localparam int LIMIT_BITS    = HOLD_BITS + 10;

    // compare width for the clamp, wide enough for coordinate and panel size
    localparam int CMP_BITS      = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;

    // configuration port
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    localparam logic [1:0] REG_PANEL_WIDTH  = 2'd0;
    localparam logic [1:0] REG_PANEL_HEIGHT = 2'd1;
    localparam logic [1:0] REG_HOLD_TIME    = 2'd2;

    localparam logic [SIZE_BITS-1:0] RESET_PANEL_WIDTH  = SIZE_BITS'(800);
    localparam logic [SIZE_BITS-1:0] RESET_PANEL_HEIGHT = SIZE_BITS'(480);
    localparam logic [HOLD_BITS-1:0] RESET_HOLD_TIME    = '0;

    // queue between front and back
    localparam int QUEUE_DEPTH   = 2;
    localparam int PTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    // poll classification
    typedef enum logic [1:0] {
        KIND_FAIL  = 2'd0,
        KIND_LIFT  = 2'd1,
        KIND_TOUCH = 2'd2
    } kind_t;

    // fault codes on the result
    typedef enum logic [FAULT_BITS-1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_READ    = 2'd1,
        FAULT_OUTSIDE = 2'd2
    } fault_t;

    // settings seen by the datapath
    typedef struct packed {
        logic [SIZE_BITS-1:0]  panel_width;
        logic [SIZE_BITS-1:0]  panel_height;
        logic                  hold_en;
        logic [LIMIT_BITS-1:0] hold_limit_us;
    } cfg_t;

    // classified poll handed from front to back
    typedef struct packed {
        kind_t                kind;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  outside;
        logic [TIME_BITS-1:0]  now_us;
        logic                  claims;
    } cmd_t;

endpackage

### src/tphq_if.sv
// channel interfaces for the touch press/hold qualifier
// depends on tphq_pkg

interface tphq_in_if;
    import tphq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  read_failed;
    logic [POINT_BITS-1:0] point_count;
    logic [COORD_BITS-1:0] touch_x;
    logic [COORD_BITS-1:0] touch_y;
    logic [TIME_BITS-1:0]  now_us;
    logic                  wake_claims_press;

    modport source (
        output valid, read_failed, point_count, touch_x, touch_y, now_us,
               wake_claims_press,
        input  ready
    );

    modport sink (
        input  valid, read_failed, point_count, touch_x, touch_y, now_us,
               wake_claims_press,
        output ready
    );
endinterface

interface tphq_out_if;
    import tphq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pointer_x;
    logic [COORD_BITS-1:0] pointer_y;
    logic                  pointer_down;
    logic                  hold_event;
    logic [FAULT_BITS-1:0] fault_code;
    logic                  press_began;

    modport source (
        output valid, pointer_x, pointer_y, pointer_down, hold_event, fault_code,
               press_began,
        input  ready
    );

    modport sink (
        input  valid, pointer_x, pointer_y, pointer_down, hold_event, fault_code,
               press_began,
        output ready
    );
endinterface

### src/tphq_cfg.sv
// configuration registers behind the apb-style port
// depends on tphq_pkg; also precomputes the hold limit in microseconds

module tphq_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tphq_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [tphq_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [tphq_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    output tphq_pkg::cfg_t                     cfg
);
    import tphq_pkg::*;

    logic [SIZE_BITS-1:0]  width_reg;
    logic [SIZE_BITS-1:0]  height_reg;
    logic [HOLD_BITS-1:0]  hold_reg;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic [LIMIT_BITS-1:0] limit_next;
    logic                  wr_en;
    logic [1:0]            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // hold time scaled to microseconds, registered at the write
    assign limit_next = LIMIT_BITS'(pwdata[HOLD_BITS-1:0]) * LIMIT_BITS'(US_PER_MS);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_PANEL_WIDTH;
            height_reg <= RESET_PANEL_HEIGHT;
            hold_reg   <= RESET_HOLD_TIME;
            limit_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_PANEL_WIDTH:  width_reg  <= pwdata[SIZE_BITS-1:0];
                REG_PANEL_HEIGHT: height_reg <= pwdata[SIZE_BITS-1:0];
                REG_HOLD_TIME:
                begin
                    hold_reg  <= pwdata[HOLD_BITS-1:0];
                    limit_reg <= limit_next;
                end
                default: ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (reg_idx)
            REG_PANEL_WIDTH:  prdata = APB_DATA_BITS'(width_reg);
            REG_PANEL_HEIGHT: prdata = APB_DATA_BITS'(height_reg);
            REG_HOLD_TIME:    prdata = APB_DATA_BITS'(hold_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.panel_width   = width_reg;
    assign cfg.panel_height  = height_reg;
    assign cfg.hold_en       = (hold_reg != '0);
    assign cfg.hold_limit_us = limit_reg;

endmodule

### src/tphq_front.sv
// front part: takes poll items, classifies them and clamps the coordinate
// depends on tphq_pkg and tphq_if; pushes classified items into the queue

module tphq_front (
    tphq_in_if.sink              in_ch,
    input  tphq_pkg::cfg_t       cfg,
    output logic                 push_valid,
    input  logic                 push_ready,
    output tphq_pkg::cmd_t       push_data
);
    import tphq_pkg::*;

    logic [SIZE_BITS-1:0] w_eff;
    logic [SIZE_BITS-1:0] h_eff;
    logic                 x_out;
    logic                 y_out;

    // a zero panel size behaves as one
    assign w_eff = (cfg.panel_width  == '0) ? SIZE_BITS'(1) : cfg.panel_width;
    assign h_eff = (cfg.panel_height == '0) ? SIZE_BITS'(1) : cfg.panel_height;

    assign x_out = CMP_BITS'(in_ch.touch_x) >= CMP_BITS'(w_eff);
    assign y_out = CMP_BITS'(in_ch.touch_y) >= CMP_BITS'(h_eff);

    // classify and clamp
    always_comb
    begin
        push_data.now_us  = in_ch.now_us;
        push_data.claims  = in_ch.wake_claims_press;
        push_data.outside = x_out || y_out;
        push_data.x       = x_out ? COORD_BITS'(w_eff - SIZE_BITS'(1)) : in_ch.touch_x;
        push_data.y       = y_out ? COORD_BITS'(h_eff - SIZE_BITS'(1)) : in_ch.touch_y;
        if (in_ch.read_failed)
            push_data.kind = KIND_FAIL;
        else if (in_ch.point_count == '0)
            push_data.kind = KIND_LIFT;
        else
            push_data.kind = KIND_TOUCH;
    end

    assign push_valid  = in_ch.valid;
    assign in_ch.ready = push_ready;

endmodule

### src/tphq_fifo.sv
// short queue between front and back parts
// depends on tphq_pkg; holds classified poll items

module tphq_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  tphq_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output tphq_pkg::cmd_t pop_data
);
    import tphq_pkg::*;

    cmd_t                mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != CNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_ready && pop_valid;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_BITS'(1);
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_BITS'(1);
        end
    end

endmodule

### src/tphq_back.sv
// back part: press state, hold timing and the registered result
// depends on tphq_pkg and tphq_if; takes classified items from the queue

module tphq_back (
    input  logic           clk,
    input  logic           rst_n,
    input  tphq_pkg::cfg_t cfg,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  tphq_pkg::cmd_t cmd_data,
    tphq_out_if.source     out_ch
);
    import tphq_pkg::*;

    // press state
    logic                  finger_down_reg, finger_down_next;
    logic                  consumed_reg,    consumed_next;
    logic                  block_reg,       block_next;
    logic                  hold_done_reg,   hold_done_next;
    logic [TIME_BITS-1:0]  start_reg,       start_next;
    logic [COORD_BITS-1:0] last_x_reg,      last_x_next;
    logic [COORD_BITS-1:0] last_y_reg,      last_y_next;

    // result register
    logic                  out_valid_reg;
    logic                  down_reg,  down_next;
    logic                  hold_reg,  hold_next;
    fault_t                fault_reg, fault_next;
    logic                  began_reg, began_next;

    logic                  take;
    logic [TIME_BITS-1:0]  held_us;
    logic                  held_enough;

    // the result slot frees whenever the sink takes it
    assign cmd_ready = !out_valid_reg || out_ch.ready;
    assign take      = cmd_valid && cmd_ready;

    // held time, only meaningful while a press is already active
    assign held_us     = cmd_data.now_us - start_reg;
    assign held_enough = held_us >= TIME_BITS'(cfg.hold_limit_us);

    // state update for one item
    always_comb
    begin
        finger_down_next = finger_down_reg;
        consumed_next    = consumed_reg;
        block_next       = block_reg;
        hold_done_next   = hold_done_reg;
        start_next       = start_reg;
        last_x_next      = last_x_reg;
        last_y_next      = last_y_reg;
        down_next        = 1'b0;
        hold_next        = 1'b0;
        fault_next       = FAULT_NONE;
        began_next       = 1'b0;
        case (cmd_data.kind)
            KIND_FAIL:
            begin
                finger_down_next = 1'b0;
                consumed_next    = 1'b0;
                hold_done_next   = 1'b0;
                fault_next       = FAULT_READ;
            end
            KIND_LIFT:
            begin
                finger_down_next = 1'b0;
                consumed_next    = 1'b0;
                hold_done_next   = 1'b0;
                block_next       = 1'b0;
            end
            KIND_TOUCH:
            begin
                last_x_next = cmd_data.x;
                last_y_next = cmd_data.y;
                if (cmd_data.outside)
                    fault_next = FAULT_OUTSIDE;
                if (!finger_down_reg)
                begin
                    // new press: held time is zero so the hold cannot fire yet
                    finger_down_next = 1'b1;
                    consumed_next    = block_reg || cmd_data.claims;
                    block_next       = block_reg || cmd_data.claims;
                    start_next       = cmd_data.now_us;
                    hold_done_next   = 1'b0;
                    began_next       = 1'b1;
                end
                else if (!hold_done_reg && cfg.hold_en && held_enough)
                begin
                    hold_done_next = 1'b1;
                    consumed_next  = 1'b1;
                    block_next     = 1'b1;
                    hold_next      = 1'b1;
                end
                down_next = !consumed_next;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            finger_down_reg <= 1'b0;
            consumed_reg    <= 1'b0;
            block_reg       <= 1'b0;
            hold_done_reg   <= 1'b0;
            start_reg       <= '0;
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                finger_down_reg <= finger_down_next;
                consumed_reg    <= consumed_next;
                block_reg       <= block_next;
                hold_done_reg   <= hold_done_next;
                start_reg       <= start_next;
                last_x_reg      <= last_x_next;
                last_y_reg      <= last_y_next;
            end
            if (take)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            down_reg  <= down_next;
            hold_reg  <= hold_next;
            fault_reg <= fault_next;
            began_reg <= began_next;
        end
    end

    // coordinates come from the updated last-known registers
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.pointer_x    = last_x_reg;
    assign out_ch.pointer_y    = last_y_reg;
    assign out_ch.pointer_down = down_reg;
    assign out_ch.hold_event   = hold_reg;
    assign out_ch.fault_code   = fault_reg;
    assign out_ch.press_began  = began_reg;

endmodule

### src/touch_press_hold_qualifier.sv
// Touch press/hold qualifier: takes one touch-controller poll per item and
// gives one result item per poll. An item is taken every cycle while the
// two-entry queue between the classify stage and the press-state stage has
// room; while the result sink is ready, the press-state stage retires one
// item per cycle, so the sustained rate is then one item per clock. A result
// is registered: the item enters the queue at acceptance and moves into the
// result register when that register is empty or its result is being taken.
// A stalled result holds the result register; a full queue stalls the input.
// Panel size and hold time are written through the apb-style port at byte
// addresses 0, 4 and 8 and should only change while no item is in flight.
// depends on tphq_pkg, tphq_if, tphq_cfg, tphq_front, tphq_fifo, tphq_back

module touch_press_hold_qualifier (
    input  logic                               clk,
    input  logic                               rst_n,
    tphq_in_if.sink                            in_ch,
    tphq_out_if.source                         out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tphq_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [tphq_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [tphq_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import tphq_pkg::*;

    cfg_t cfg;
    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_data;

    // configuration registers
    tphq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // classify and clamp
    tphq_front u_front (
        .in_ch      (in_ch),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue
    tphq_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // press state and result
    tphq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd_data  (pop_data),
        .out_ch    (out_ch)
    );

endmodule
